@@ rtl/chs_pkg.sv @@
`default_nettype none

package chs_pkg;

	localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
	localparam int unsigned SLOTS = 6;
	localparam int unsigned NUM_W = $clog2(SLOTS + 1);
	localparam int unsigned IDX_W = $clog2(SLOTS);

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [1:0] {
		KIND_NAME       = 2'd0,
		KIND_VALUE      = 2'd1,
		KIND_COOKIE_END = 2'd2,
		KIND_HEADER_END = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	typedef struct packed {
		logic [7:0]  data;
		kind_t       kind;
		logic [15:0] count;
	} result_t;

	typedef struct packed {
		logic [NUM_W-1:0]        num;
		result_t [SLOTS-1:0]     slot;
	} bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = 8'h00;
		end
		return v[3:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/chs_in_if.sv @@
`default_nettype none

interface chs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       has_byte;
	logic       end_of_header;

	modport source (output valid, byte_in, has_byte, end_of_header, input ready);
	modport sink   (input valid, byte_in, has_byte, end_of_header, output ready);
endinterface

`default_nettype wire

@@ rtl/chs_out_if.sv @@
`default_nettype none

interface chs_out_if import chs_pkg::*;;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	kind_t       result_kind;
	logic [15:0] cookie_count;
	logic        last_of_run;

	modport source (output valid, out_byte, result_kind, cookie_count, last_of_run,
		input ready);
	modport sink   (input valid, out_byte, result_kind, cookie_count, last_of_run,
		output ready);
endinterface

`default_nettype wire

@@ rtl/chs_core.sv @@
`default_nettype none

module chs_core import chs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] byte_in,
	input  wire logic       has_byte,
	input  wire logic       end_of_header,
	output bundle_t         bundle
);

	logic                   value_q;
	esc_t                   esc_q;
	logic [7:0]             held_q;
	logic                   semi_q;
	logic                   seg_q;
	logic                   stop_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic                   value_d;
	esc_t                   esc_d;
	logic [7:0]             held_d;
	logic                   semi_d;
	logic                   seg_d;
	logic                   stop_d;
	logic [COUNT_WIDTH-1:0] cnt_d;

	function automatic bundle_t push(input bundle_t b, input logic [7:0] d, input kind_t k,
		input logic [15:0] c);
		bundle_t r;
		r = b;
		r.slot[r.num[IDX_W-1:0]].data  = d;
		r.slot[r.num[IDX_W-1:0]].kind  = k;
		r.slot[r.num[IDX_W-1:0]].count = c;
		r.num = r.num + 1'b1;
		return r;
	endfunction

	always_comb begin : step_logic
		bundle_t                b;
		logic                   val;
		esc_t                   esc;
		logic [7:0]             held;
		logic                   semi;
		logic                   seg;
		logic                   stop;
		logic [COUNT_WIDTH-1:0] cnt;
		logic                   done;
		logic                   do_take;
		logic                   do_finish;
		logic [7:0]             dec;

		b         = '0;
		val       = value_q;
		esc       = esc_q;
		held      = held_q;
		semi      = semi_q;
		seg       = seg_q;
		stop      = stop_q;
		cnt       = cnt_q;
		done      = 1'b0;
		dec       = {hex_nibble(held_q), hex_nibble(byte_in)};
		do_take   = has_byte && !stop_q && byte_in != CH_NUL;
		do_finish = !stop_q && ((has_byte && byte_in == CH_NUL) || end_of_header);

		if (do_take) begin
			seg = 1'b1;
			if (semi) begin
				semi = 1'b0;
				if (byte_in == CH_SPACE) begin
					if (cnt != '1) begin
						cnt = cnt + 1'b1;
					end
					b    = push(b, CH_NUL, KIND_COOKIE_END, 16'(cnt));
					seg  = 1'b0;
					val  = 1'b0;
					done = 1'b1;
				end else begin
					b = push(b, CH_SEMI, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
				end
			end
			if (!done) begin
				case (esc)
					ESC_PCT: begin
						if (is_hex(byte_in)) begin
							held = byte_in;
							esc  = ESC_DIGIT;
							done = 1'b1;
						end else begin
							b   = push(b, CH_PERCENT, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
							esc = ESC_NONE;
						end
					end
					ESC_DIGIT: begin
						esc = ESC_NONE;
						if (is_hex(byte_in)) begin
							if (dec != CH_NUL) begin
								b = push(b, dec, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
							end
							done = 1'b1;
						end else begin
							b = push(b, CH_PERCENT, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
							b = push(b, held, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
						end
					end
					default: begin
					end
				endcase
			end
			if (!done) begin
				if (byte_in == CH_SEMI) begin
					semi = 1'b1;
				end else if (!val) begin
					if (byte_in == CH_EQUALS) begin
						val = 1'b1;
					end else begin
						b = push(b, byte_in, KIND_NAME, 16'(cnt));
					end
				end else if (byte_in == CH_PERCENT) begin
					esc = ESC_PCT;
				end else begin
					b = push(b, byte_in, KIND_VALUE, 16'(cnt));
				end
			end
		end

		if (do_finish) begin
			if (esc != ESC_NONE) begin
				b = push(b, CH_PERCENT, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
			end
			if (esc == ESC_DIGIT) begin
				b = push(b, held, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
			end
			esc = ESC_NONE;
			if (semi) begin
				b    = push(b, CH_SEMI, val ? KIND_VALUE : KIND_NAME, 16'(cnt));
				semi = 1'b0;
			end
			if (seg) begin
				if (cnt != '1) begin
					cnt = cnt + 1'b1;
				end
				b   = push(b, CH_NUL, KIND_COOKIE_END, 16'(cnt));
				seg = 1'b0;
				val = 1'b0;
			end
			if (has_byte && byte_in == CH_NUL) begin
				stop = 1'b1;
			end
		end

		if (end_of_header) begin
			b    = push(b, CH_NUL, KIND_HEADER_END, 16'(cnt));
			val  = 1'b0;
			esc  = ESC_NONE;
			held = CH_NUL;
			semi = 1'b0;
			seg  = 1'b0;
			stop = 1'b0;
			cnt  = '0;
		end

		bundle  = b;
		value_d = val;
		esc_d   = esc;
		held_d  = held;
		semi_d  = semi;
		seg_d   = seg;
		stop_d  = stop;
		cnt_d   = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= 1'b0;
			esc_q   <= ESC_NONE;
			held_q  <= CH_NUL;
			semi_q  <= 1'b0;
			seg_q   <= 1'b0;
			stop_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			value_q <= value_d;
			esc_q   <= esc_d;
			held_q  <= held_d;
			semi_q  <= semi_d;
			seg_q   <= seg_d;
			stop_q  <= stop_d;
			cnt_q   <= cnt_d;
		end
	end

	a_semi_no_escape: assert property (@(posedge clk) disable iff (!arst_n)
		semi_q |-> esc_q == ESC_NONE)
		else $error("held semicolon with escape pending");

	a_stop_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> !seg_q && !semi_q && esc_q == ESC_NONE && !value_q)
		else $error("state left open after zero byte");

	a_header_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_header |=> cnt_q == '0 && !stop_q)
		else $error("header end did not clear state");

endmodule

`default_nettype wire

@@ rtl/chs_queue.sv @@
`default_nettype none

module chs_queue import chs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  bundle_t    load_data,
	output logic       free,
	chs_out_if.source  result
);

	bundle_t          bund_s1;
	logic             busy_q;
	logic [IDX_W-1:0] rd_q;
	result_t          cur;
	logic             last;
	logic             fire;

	assign cur  = bund_s1.slot[rd_q];
	assign last = (NUM_W'(rd_q) + 1'b1) == bund_s1.num;
	assign fire = result.valid && result.ready;
	assign free = !busy_q || (fire && last);

	assign result.valid        = busy_q;
	assign result.out_byte     = cur.data;
	assign result.result_kind  = cur.kind;
	assign result.cookie_count = cur.count;
	assign result.last_of_run  = last;

	always_ff @(posedge clk) begin
		if (load) begin
			bund_s1 <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rd_q   <= '0;
		end else if (fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> NUM_W'(rd_q) < bund_s1.num)
		else $error("read index past word count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("bundle loaded over pending words");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last && !load |=> busy_q && rd_q == $past(rd_q) + 1'b1)
		else $error("read index did not advance");

endmodule

`default_nettype wire

@@ rtl/cookie_header_splitter.sv @@
// Cookie header splitter.
// header: one header byte per word (byte_in, has_byte, end_of_header), valid/ready.
// result: one tagged byte per word (out_byte, result_kind, cookie_count,
//   last_of_run), valid/ready. result_kind: name byte, value byte, cookie end,
//   header end. last_of_run marks the final word caused by one header word.
// Each header word is decoded in the cycle it is accepted; its results (zero to
// five words) are loaded into a result register and leave one per cycle while
// the receiver is ready, the first presented in the cycle after acceptance.
// A header word that causes at most one result is taken every cycle while the
// receiver is ready. One that causes more holds ready low until its last result
// is taken, since the single result register must drain first.
// A header word causing no result is absorbed without touching the result side.
// Receiver stall: the pending word holds steady, and the header side is taken
// again once the last pending word leaves, in that same cycle.
// Reset: parser state and cookie count clear, the result register empties, and
// the block is ready for a header word straight out of reset.
// End of header emits a header-end word with the final count and returns the
// parser to its reset state for the next header.
`default_nettype none

module cookie_header_splitter import chs_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	chs_in_if.sink    header,
	chs_out_if.source result
);

	bundle_t core_bundle;
	logic    accept;
	logic    free;

	assign header.ready = free;
	assign accept       = header.valid && header.ready;

	chs_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.byte_in       (header.byte_in),
		.has_byte      (header.has_byte),
		.end_of_header (header.end_of_header),
		.bundle        (core_bundle)
	);

	chs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && core_bundle.num != '0),
		.load_data (core_bundle),
		.free      (free),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ tb/chs_check_pkg.sv @@
package chs_check_pkg;
	import chs_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		kind_t       kind;
		logic [15:0] count;
		logic        last;
	} cookie_word_t;

	class cookie_scoreboard;
		cookie_word_t      expected_words[$];
		cookie_word_t      step_words[$];
		bit                in_value;
		esc_t              esc_state;
		logic [7:0]        first_digit;
		bit                semi_pending;
		bit                cookie_open;
		bit                text_stopped;
		longint unsigned   completed;
		longint unsigned   count_max;
		int                mismatches;

		function new(int unsigned count_width);
			count_max = (64'd1 << count_width) - 64'd1;
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			in_value = 0;
			esc_state = ESC_NONE;
			first_digit = 8'h00;
			semi_pending = 0;
			cookie_open = 0;
			text_stopped = 0;
			completed = 0;
		endfunction

		function int hex_of(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return int'(c) - int'("0");
			end
			if (c >= "a" && c <= "f") begin
				return int'(c) - int'("a") + 10;
			end
			if (c >= "A" && c <= "F") begin
				return int'(c) - int'("A") + 10;
			end
			return -1;
		endfunction

		function void emit(logic [7:0] data, kind_t kind);
			cookie_word_t w;
			if (step_words.size() >= SLOTS) begin
				return;
			end
			w.data = data;
			w.kind = kind;
			w.count = completed[15:0];
			w.last = 1'b0;
			step_words.push_back(w);
		endfunction

		function void emit_char(logic [7:0] c);
			emit(c, in_value ? KIND_VALUE : KIND_NAME);
		endfunction

		function void end_cookie();
			if (completed < count_max) begin
				completed++;
			end
			emit(CH_NUL, KIND_COOKIE_END);
			cookie_open = 0;
			in_value = 0;
		endfunction

		function void plain_char(logic [7:0] c);
			if (c == CH_SEMI) begin
				semi_pending = 1;
			end else if (!in_value) begin
				if (c == CH_EQUALS) begin
					in_value = 1;
				end else begin
					emit_char(c);
				end
			end else if (c == CH_PERCENT) begin
				esc_state = ESC_PCT;
			end else begin
				emit_char(c);
			end
		endfunction

		function void take_char(logic [7:0] c);
			int         h;
			logic [7:0] v;
			cookie_open = 1;
			if (semi_pending) begin
				semi_pending = 0;
				if (c == CH_SPACE) begin
					end_cookie();
					return;
				end
				emit_char(CH_SEMI);
			end
			h = hex_of(c);
			if (esc_state == ESC_PCT) begin
				if (h >= 0) begin
					first_digit = c;
					esc_state = ESC_DIGIT;
					return;
				end
				emit_char(CH_PERCENT);
				esc_state = ESC_NONE;
			end else if (esc_state == ESC_DIGIT) begin
				esc_state = ESC_NONE;
				if (h >= 0) begin
					v = 8'(hex_of(first_digit) * 16 + h);
					if (v != 8'h00) begin
						emit_char(v);
					end
					return;
				end
				emit_char(CH_PERCENT);
				emit_char(first_digit);
			end
			plain_char(c);
		endfunction

		function void flush_text();
			if (esc_state != ESC_NONE) begin
				emit_char(CH_PERCENT);
			end
			if (esc_state == ESC_DIGIT) begin
				emit_char(first_digit);
			end
			esc_state = ESC_NONE;
			if (semi_pending) begin
				emit_char(CH_SEMI);
				semi_pending = 0;
			end
			if (cookie_open) begin
				end_cookie();
			end
		endfunction

		function void note_header(logic [7:0] b, logic has, logic eoh);
			cookie_word_t w;
			step_words.delete();
			if (has && !text_stopped) begin
				if (b == CH_NUL) begin
					flush_text();
					text_stopped = 1;
				end else begin
					take_char(b);
				end
			end
			if (eoh) begin
				if (!text_stopped) begin
					flush_text();
				end
				emit(CH_NUL, KIND_HEADER_END);
				clear();
			end
			foreach (step_words[i]) begin
				w = step_words[i];
				w.last = (i == step_words.size() - 1);
				expected_words.push_back(w);
			end
		endfunction

		function void fail(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function void check_result(logic [7:0] data, kind_t kind, logic [15:0] count,
			logic last);
			cookie_word_t want;
			if (expected_words.size() == 0) begin
				fail($sformatf("unexpected word: byte %h kind %0d count %0d last %b",
					data, kind, count, last));
				return;
			end
			want = expected_words.pop_front();
			if (want.data !== data || want.kind !== kind || want.count !== count ||
				want.last !== last) begin
				fail($sformatf({"word mismatch: expected byte %h kind %0d count %0d last %b,",
					" got byte %h kind %0d count %0d last %b"}, want.data, want.kind,
					want.count, want.last, data, kind, count, last));
			end
		endfunction
	endclass

endpackage

@@ tb/tb_cookie_header_splitter.sv @@
module tb_cookie_header_splitter;
	import chs_pkg::*;
	import chs_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n;

	chs_in_if  hdr();
	chs_out_if res();

	cookie_header_splitter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.header (hdr),
		.result (res)
	);

	cookie_scoreboard board = new(COUNT_WIDTH_DEFAULT);

	bit          sender_idles;
	bit          receiver_idles;
	int unsigned hold_request;
	int unsigned words_sent;
	logic [7:0]  header_text[$];

	always #5 clk = ~clk;

	task automatic send_word(input logic [7:0] b, input logic has, input logic eoh);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			hdr.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr.valid <= 1'b1;
		hdr.byte_in <= b;
		hdr.has_byte <= has;
		hdr.end_of_header <= eoh;
		@(posedge clk);
		while (hdr.ready !== 1'b1) @(posedge clk);
		board.note_header(b, has, eoh);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], 1'b1, 1'b0);
		end
	endtask

	function automatic logic [7:0] hex_char();
		int unsigned r;
		r = $urandom_range(0, 21);
		if (r < 10) begin
			return 8'("0" + r);
		end
		if (r < 16) begin
			return 8'("a" + r - 10);
		end
		return 8'("A" + r - 16);
	endfunction

	function automatic logic [7:0] non_hex_char();
		case ($urandom_range(0, 3))
			0: return CH_PERCENT;
			1: return CH_SEMI;
			2: return CH_SPACE;
			default: return 8'("g" + $urandom_range(0, 19));
		endcase
	endfunction

	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			default: return 8'($urandom_range(8'h21, 8'h7E));
		endcase
	endfunction

	task automatic add_value_piece();
		case ($urandom_range(0, 9))
			0, 1, 2: header_text.push_back(8'("a" + $urandom_range(0, 25)));
			3, 4: begin
				header_text.push_back(CH_PERCENT);
				header_text.push_back(hex_char());
				header_text.push_back(hex_char());
			end
			5: begin
				header_text.push_back(CH_PERCENT);
				header_text.push_back("0");
				header_text.push_back(hex_char());
			end
			6: begin
				header_text.push_back(CH_PERCENT);
				header_text.push_back(hex_char());
				header_text.push_back(non_hex_char());
			end
			7: begin
				header_text.push_back(CH_PERCENT);
				header_text.push_back(non_hex_char());
			end
			8: header_text.push_back(8'($urandom_range(1, 255)));
			default: header_text.push_back($urandom_range(0, 1) ? CH_SEMI : CH_EQUALS);
		endcase
	endtask

	task automatic build_header();
		int unsigned cookies;
		int unsigned len;
		header_text.delete();
		cookies = $urandom_range(1, 4);
		for (int k = 0; k < cookies; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 6);
				repeat (len) header_text.push_back(8'($urandom_range(1, 255)));
			end else begin
				len = $urandom_range(0, 4);
				repeat (len) header_text.push_back(name_char());
				if ($urandom_range(0, 7) != 0) begin
					header_text.push_back(CH_EQUALS);
				end
				len = $urandom_range(0, 5);
				repeat (len) add_value_piece();
			end
			if (k < cookies - 1 || $urandom_range(0, 3) == 0) begin
				header_text.push_back(CH_SEMI);
				header_text.push_back(CH_SPACE);
			end
		end
		case ($urandom_range(0, 9))
			0: header_text.push_back(CH_PERCENT);
			1: begin
				header_text.push_back(CH_PERCENT);
				header_text.push_back(hex_char());
			end
			2: header_text.push_back(CH_SEMI);
			3: header_text.insert($urandom_range(0, header_text.size()), CH_NUL);
			default: ;
		endcase
	endtask

	task automatic send_header();
		bit eoh_on_last;
		eoh_on_last = $urandom_range(0, 1);
		foreach (header_text[i]) begin
			if ($urandom_range(0, 14) == 0) begin
				send_word(8'($urandom), 1'b0, 1'b0);
			end
			send_word(header_text[i], 1'b1, eoh_on_last && i == header_text.size() - 1);
		end
		if (!eoh_on_last || header_text.size() == 0) begin
			send_word(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic run_headers(input int unsigned words);
		int unsigned stop_at;
		stop_at = words_sent + words;
		while (words_sent < stop_at) begin
			build_header();
			send_header();
		end
	endtask

	initial begin
		int unsigned gap;
		res.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request != 0) begin
				gap = hold_request;
				hold_request = 0;
			end else begin
				gap = receiver_idles ? $urandom_range(0, 6) : 0;
			end
			if (gap != 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (res.valid !== 1'b1) @(posedge clk);
			board.check_result(res.out_byte, res.result_kind, res.cookie_count,
				res.last_of_run);
		end
	end

	initial begin
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((hdr.valid === 1'b1 && hdr.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1)) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		hold_request = 0;
		words_sent = 0;
		sender_idles = 1;
		receiver_idles = 1;
		arst_n <= 1'b0;
		hdr.valid <= 1'b0;
		hdr.byte_in <= 8'h00;
		hdr.has_byte <= 1'b0;
		hdr.end_of_header <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_text("=%4a%00%4G; ; ");
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h5A, 1'b0, 1'b0);
		send_word(CH_EQUALS, 1'b1, 1'b0);
		send_word(CH_PERCENT, 1'b1, 1'b0);
		send_word(CH_SEMI, 1'b1, 1'b1);
		send_text("v=%4");
		send_word(CH_SEMI, 1'b1, 1'b1);
		send_word(CH_NUL, 1'b1, 1'b0);
		send_word("y", 1'b1, 1'b0);
		send_word(CH_NUL, 1'b0, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			sender_idles = (phase == 0 || phase == 2);
			receiver_idles = (phase == 0 || phase == 3);
			run_headers(15);
		end

		// back up the result side so the header side stalls
		sender_idles = 0;
		receiver_idles = 1;
		hold_request = 150;
		run_headers(20);

		sender_idles = 1;
		receiver_idles = 1;
		run_headers(5);

		hdr.valid <= 1'b0;
		while (board.expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.expected_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/chs_pkg.sv
rtl/chs_in_if.sv
rtl/chs_out_if.sv
rtl/chs_core.sv
rtl/chs_queue.sv
rtl/cookie_header_splitter.sv
tb/chs_check_pkg.sv
tb/tb_cookie_header_splitter.sv
